### sv/mf3g_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3g_pkg
// Shared constants and types for the 3x3 grey median filter.
// ----------------------------------------------------------------------------
package mf3g_pkg;

  localparam int PIX_W         = 8;
  localparam int COORD_W       = 11;
  localparam int CFG_W         = 12;
  localparam int CFG_IDX_W     = 1;
  localparam int DEF_MAX_WIDTH = 2048;
  localparam int MAX_HEIGHT    = 2048;
  localparam int MIN_DIM       = 3;
  localparam int WIN_SIDE      = 3;
  localparam int WIN_N         = WIN_SIDE * WIN_SIDE;
  localparam int MED_IDX       = 4;
  localparam int OUT_DEPTH     = 8;

  // grey = (r+g+b)/3 as (sum * 2731) >> 13, exact for sums up to 765
  localparam int SUM_W      = PIX_W + 2;
  localparam int GREY_RECIP = 2731;
  localparam int GREY_SHIFT = 13;
  localparam int PROD_W     = SUM_W + $clog2(GREY_RECIP);

  localparam logic [CFG_W-1:0] WIDTH_RST  = 12'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 12'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [WIN_N-1:0] win_t;

  typedef struct packed {
    logic               emit;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
  } tag_t;

  typedef struct packed {
    pix_t               median;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
  } res_t;

endpackage

### sv/median3x3_grey_filter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median3x3_grey_filter_core
// 3x3 median filter on the grey value of an RGB raster pixel stream.
//
// Pixels enter on in_* (valid/ready), in raster order; in_frame_start marks
// the first pixel of a frame and resets the column and row counters.
// Each pixel whose 3x3 window is fully inside the frame yields one
// transaction on out_* with the median grey and the centre coordinates;
// border pixels yield nothing. Frame width and height are written on
// cfg_* (index 0 / 1) while the stream is idle; cfg_ready is always high.
// Throughput: one pixel per cycle while in_ready is high, set by the single
// RAM read port and the write-back of the same entry in the following cycle
// (forwarded when two consecutive pixels share a column).
// Path: a result reaches out_valid through the line RAM read at the accepting
// edge, the window registers, two sort stages and the result queue.
// Reset: the line RAM is swept to zero entry by entry, and in_ready stays low
// during the sweep. Stall: an 8-entry result queue with credit tracking
// lets input continue while results wait; in_ready drops once eight
// pixels are outstanding.
// ----------------------------------------------------------------------------
module median3x3_grey_filter_core #(
  parameter int MAX_WIDTH = mf3g_pkg::DEF_MAX_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [mf3g_pkg::PIX_W-1:0]      in_red,
  input  logic [mf3g_pkg::PIX_W-1:0]      in_green,
  input  logic [mf3g_pkg::PIX_W-1:0]      in_blue,
  input  logic                            in_frame_start,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [mf3g_pkg::PIX_W-1:0]      out_median_value,
  output logic [mf3g_pkg::COORD_W-1:0]    out_centre_x,
  output logic [mf3g_pkg::COORD_W-1:0]    out_centre_y,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mf3g_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mf3g_pkg::CFG_W-1:0]      cfg_data
);
  import mf3g_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int WW = (XW + 1 > CFG_W) ? XW + 1 : CFG_W;
  localparam int PW = $clog2(OUT_DEPTH + 1);

  logic [CFG_W-1:0]   width_cfg_r, height_cfg_r;
  logic [WW-1:0]      width_eff;
  logic [CFG_W-1:0]   height_eff;

  logic [XW-1:0]      col_r, col_nxt, col_cur;
  logic [COORD_W-1:0] row_r, row_nxt, row_cur;
  logic [WW-1:0]      col_inc, cx_full;
  logic [CFG_W-1:0]   row_inc;
  logic               in_acc;
  tag_t               in_tag;

  logic [SUM_W-1:0]   sum;
  logic [PROD_W-1:0]  prod;
  pix_t               grey;

  logic [PW-1:0]      pending_r, pending_nxt;
  logic               clr_busy, win_valid, drop, med_valid, pop;
  win_t               win;
  tag_t               win_tag;
  res_t               med_res, out_res;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_cfg_r  <= WIDTH_RST;
      height_cfg_r <= HEIGHT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_WIDTH:  width_cfg_r  <= cfg_data;
        CFG_HEIGHT: height_cfg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    width_eff = WW'(width_cfg_r);
    if (width_eff < WW'(MIN_DIM)) begin
      width_eff = WW'(MIN_DIM);
    end else if (width_eff > WW'(MAX_WIDTH)) begin
      width_eff = WW'(MAX_WIDTH);
    end
    height_eff = height_cfg_r;
    if (height_eff < CFG_W'(MIN_DIM)) begin
      height_eff = CFG_W'(MIN_DIM);
    end else if (height_eff > CFG_W'(MAX_HEIGHT)) begin
      height_eff = CFG_W'(MAX_HEIGHT);
    end
  end

  // position of the incoming pixel and counter advance
  assign in_acc  = in_valid && in_ready;
  assign col_cur = in_frame_start ? '0 : col_r;
  assign row_cur = in_frame_start ? '0 : row_r;
  assign col_inc = WW'(col_cur) + WW'(1);
  assign row_inc = CFG_W'(row_cur) + CFG_W'(1);
  assign cx_full = WW'(col_cur) - WW'(1);

  always_comb begin
    col_nxt = col_inc[XW-1:0];
    row_nxt = row_cur;
    if (col_inc >= width_eff) begin
      col_nxt = '0;
      row_nxt = (row_inc >= height_eff) ? '0 : row_inc[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign in_tag.emit = (col_cur >= XW'(2)) && (row_cur >= COORD_W'(2)) &&
                       (WW'(col_cur) < width_eff) && (CFG_W'(row_cur) < height_eff);
  assign in_tag.cx   = cx_full[COORD_W-1:0];
  assign in_tag.cy   = row_cur - COORD_W'(1);

  // grey conversion
  assign sum  = SUM_W'(in_red) + SUM_W'(in_green) + SUM_W'(in_blue);
  assign prod = PROD_W'(sum) * PROD_W'(GREY_RECIP);
  assign grey = prod[GREY_SHIFT +: PIX_W];

  // credits: every accepted pixel holds one until dropped or delivered
  assign drop        = win_valid && !win_tag.emit;
  assign pop         = out_valid && out_ready;
  assign pending_nxt = pending_r + PW'(in_acc) - PW'(drop) - PW'(pop);
  assign in_ready    = !clr_busy && (pending_r < PW'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  mf3g_line_buf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_lbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_acc),
    .in_addr   (col_cur),
    .in_grey   (grey),
    .in_tag    (in_tag),
    .clr_busy  (clr_busy),
    .win_valid (win_valid),
    .win       (win),
    .win_tag   (win_tag)
  );

  mf3g_median9 u_med (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (win_valid && win_tag.emit),
    .in_win    (win),
    .in_tag    (win_tag),
    .out_valid (med_valid),
    .out_res   (med_res)
  );

  mf3g_res_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (med_valid),
    .push_data (med_res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_median_value = out_res.median;
  assign out_centre_x     = out_res.cx;
  assign out_centre_y     = out_res.cy;

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= PW'(OUT_DEPTH))
    else $error("outstanding pixel count exceeds queue depth");

  a_frame_start_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_frame_start) |=> (col_r == XW'(1) && row_r == '0))
    else $error("frame start did not restart position counters");

endmodule

### sv/mf3g_line_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3g_line_buf
// Two line stores packed in one RAM entry per column, read-modify-write with
// write forwarding, zero sweep after reset, and the 3x3 window registers.
// ----------------------------------------------------------------------------
module mf3g_line_buf #(
  parameter int MAX_WIDTH = mf3g_pkg::DEF_MAX_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [$clog2(MAX_WIDTH)-1:0] in_addr,
  input  mf3g_pkg::pix_t               in_grey,
  input  mf3g_pkg::tag_t               in_tag,
  output logic                         clr_busy,
  output logic                         win_valid,
  output mf3g_pkg::win_t               win,
  output mf3g_pkg::tag_t               win_tag
);
  import mf3g_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);

  typedef struct packed {
    pix_t upper;
    pix_t lower;
  } ent_t;

  ent_t          mem [MAX_WIDTH];
  ent_t          rd_r;
  logic          clr_busy_r;
  logic [XW-1:0] clr_addr_r;

  logic          s1_valid_r;
  logic [XW-1:0] s1_addr_r;
  pix_t          s1_grey_r;
  tag_t          s1_tag_r;
  logic          fwd_hit_r;
  ent_t          fwd_data_r;

  ent_t          cur;
  ent_t          wr_data;
  win_t          win_r;
  win_t          win_nxt;
  logic          win_valid_r;
  tag_t          win_tag_r;

  // the entry written at this edge is not yet visible in the RAM read data
  assign cur     = fwd_hit_r ? fwd_data_r : rd_r;
  assign wr_data = {cur.lower, s1_grey_r};

  always_ff @(posedge clk) begin
    if (in_valid) begin
      rd_r <= mem[in_addr];
    end
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (s1_valid_r) begin
      mem[s1_addr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      if (clr_addr_r == XW'(MAX_WIDTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + XW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
      fwd_hit_r  <= in_valid && s1_valid_r && (in_addr == s1_addr_r);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      s1_addr_r  <= in_addr;
      s1_grey_r  <= in_grey;
      s1_tag_r   <= in_tag;
      fwd_data_r <= wr_data;
    end
  end

  always_comb begin
    for (int r = 0; r < WIN_SIDE; r++) begin
      win_nxt[r*WIN_SIDE]     = win_r[r*WIN_SIDE + 1];
      win_nxt[r*WIN_SIDE + 1] = win_r[r*WIN_SIDE + 2];
    end
    win_nxt[WIN_SIDE - 1]       = cur.upper;
    win_nxt[2*WIN_SIDE - 1]     = cur.lower;
    win_nxt[WIN_N - 1]          = s1_grey_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= '0;
      win_valid_r <= 1'b0;
    end else begin
      win_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        win_r <= win_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      win_tag_r <= s1_tag_r;
    end
  end

  assign clr_busy  = clr_busy_r;
  assign win_valid = win_valid_r;
  assign win       = win_r;
  assign win_tag   = win_tag_r;

  a_no_access_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid |-> !clr_busy_r)
    else $error("pixel accepted during line store sweep");

  a_fwd_on_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && $past(s1_valid_r) && (s1_addr_r == $past(s1_addr_r))) |-> fwd_hit_r)
    else $error("same-column back-to-back access not forwarded");

endmodule

### sv/mf3g_median9.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3g_median9
// Median of nine by a 19 compare-swap network split over three stages.
// ----------------------------------------------------------------------------
module mf3g_median9 (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  mf3g_pkg::win_t in_win,
  input  mf3g_pkg::tag_t in_tag,
  output logic           out_valid,
  output mf3g_pkg::res_t out_res
);
  import mf3g_pkg::*;

  function automatic win_t cas(input win_t p, input int a, input int b);
    win_t q;
    q = p;
    if (p[a] > p[b]) begin
      q[a] = p[b];
      q[b] = p[a];
    end
    return q;
  endfunction

  win_t sa, sb, sc;
  win_t sa_r, sb_r;
  logic sa_valid_r, sb_valid_r;
  tag_t sa_tag_r, sb_tag_r;

  // rows sorted
  always_comb begin
    sa = in_win;
    sa = cas(sa, 1, 2); sa = cas(sa, 4, 5); sa = cas(sa, 7, 8);
    sa = cas(sa, 0, 1); sa = cas(sa, 3, 4); sa = cas(sa, 6, 7);
    sa = cas(sa, 1, 2); sa = cas(sa, 4, 5); sa = cas(sa, 7, 8);
  end

  always_comb begin
    sb = sa_r;
    sb = cas(sb, 0, 3); sb = cas(sb, 5, 8); sb = cas(sb, 4, 7);
    sb = cas(sb, 3, 6); sb = cas(sb, 1, 4); sb = cas(sb, 2, 5);
  end

  always_comb begin
    sc = sb_r;
    sc = cas(sc, 4, 7); sc = cas(sc, 4, 2);
    sc = cas(sc, 6, 4); sc = cas(sc, 4, 2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_valid_r <= 1'b0;
      sb_valid_r <= 1'b0;
    end else begin
      sa_valid_r <= in_valid;
      sb_valid_r <= sa_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      sa_r     <= sa;
      sa_tag_r <= in_tag;
    end
    if (sa_valid_r) begin
      sb_r     <= sb;
      sb_tag_r <= sa_tag_r;
    end
  end

  assign out_valid      = sb_valid_r;
  assign out_res.median = sc[MED_IDX];
  assign out_res.cx     = sb_tag_r.cx;
  assign out_res.cy     = sb_tag_r.cy;

endmodule

### sv/mf3g_res_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3g_res_fifo
// Small result queue between the median pipeline and the output channel.
// ----------------------------------------------------------------------------
module mf3g_res_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mf3g_pkg::res_t push_data,
  output logic           out_valid,
  input  logic           out_ready,
  output mf3g_pkg::res_t out_res
);
  import mf3g_pkg::*;

  localparam int AW = $clog2(OUT_DEPTH);
  localparam int CW = $clog2(OUT_DEPTH + 1);

  res_t          slot_r [OUT_DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          pop;

  assign out_valid = (count_r != '0);
  assign pop       = out_valid && out_ready;
  assign out_res   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
      count_r <= count_r + CW'(push) - CW'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r < CW'(OUT_DEPTH)))
    else $error("result queue overflow");

endmodule
